>>> sv/tcpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpu_pkg
// Shared constants and types of the tiny 16-bit processor core.
// ----------------------------------------------------------------------------
package tcpu_pkg;

  localparam int XLEN = 16;

  // Item kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_STEP = 2'd1;
  localparam logic [1:0] KIND_SRST = 2'd2;

  // Opcodes, instruction bits 15:11
  localparam logic [4:0] OP_SET = 5'd0;
  localparam logic [4:0] OP_ADD = 5'd1;
  localparam logic [4:0] OP_ADI = 5'd2;
  localparam logic [4:0] OP_SUB = 5'd3;
  localparam logic [4:0] OP_MUL = 5'd4;
  localparam logic [4:0] OP_DIV = 5'd5;
  localparam logic [4:0] OP_NOT = 5'd10;
  localparam logic [4:0] OP_JMP = 5'd14;

  localparam logic [XLEN-1:0] HALT_PC = 16'hFFFF;

  typedef struct packed {
    logic            start;
    logic [XLEN-1:0] dividend;
    logic [XLEN-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [XLEN-1:0] quotient;
  } div_rsp_t;

endpackage

>>> sv/tiny_16bit_cpu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_16bit_cpu_core
// Small 16-bit processor: eight registers, PC, word memory, one item at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item: kind_i selects a
//   memory load (address_i, data_i), one instruction step, or a soft reset.
//   Output channel (out_valid_o/out_ready_i) returns exactly one result item
//   per input item, in order.
// Path from accept to the output stage, per kind of item:
//   load, soft reset, unused kind, halted step : straight to the output stage
//   executed step                              : fetch, decode/read, execute,
//                                                then the output stage
//   DIV with nonzero divisor                   : as an executed step, plus the
//                                                bit-serial divider (16 steps)
//   One item is in flight at a time; in_ready_o is high again once the
//   previous result sits in the output register, so the next item can be
//   taken while that result still waits for the receiver.
// The word memory and the register file are synchronous memories with
//   registered read data; the step reads memory, then the register file, then
//   executes and writes back. Accesses never overlap, so no forwarding.
// Reset: state machine, PC, instruction register and register-file valid
//   bits are cleared; memory content is undefined until loaded.
// Stall: a held result stays in the output register; the following result
//   waits in the result register until the output register frees up.
// ----------------------------------------------------------------------------
module tiny_16bit_cpu_core
  import tcpu_pkg::*;
#(
  parameter int MEM_WORDS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] address_i,
  input  logic [15:0] data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] program_counter_o,
  output logic [15:0] instruction_o,
  output logic        halted_o,
  output logic        reg_written_o,
  output logic [2:0]  reg_index_o,
  output logic [15:0] reg_value_o
);

  localparam int AW     = $clog2(MEM_WORDS);
  localparam int FLog   = $clog2(MEM_WORDS + 1) - 1;  // floor(log2)
  localparam int WSteps = XLEN - FLog;                // reduction steps

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [XLEN-1:0] pc;
    logic [XLEN-1:0] instr;
    logic            halted;
    logic            wr;
    logic [2:0]      idx;
    logic [XLEN-1:0] val;
  } res_t;

  // Address modulo MEM_WORDS by conditional subtraction of shifted sizes;
  // a power-of-two size reduces to a plain truncation.
  function automatic logic [AW-1:0] wrap_addr(input logic [XLEN-1:0] a);
    logic [XLEN:0] r;
    r = {1'b0, a};
    for (int k = WSteps - 1; k >= 0; k--) begin
      if (r >= ((XLEN+1)'(MEM_WORDS) << k)) begin
        r = r - ((XLEN+1)'(MEM_WORDS) << k);
      end
    end
    return r[AW-1:0];
  endfunction

  state_e          state_q;
  logic [XLEN-1:0] pc_q;
  logic [XLEN-1:0] instr_q;
  logic [7:0]      rf_vld_q;
  res_t            res_q;
  res_t            out_q;
  logic            out_valid_q;

  logic            in_acc;

  // word memory
  logic [XLEN-1:0] mem_q [MEM_WORDS];
  logic [XLEN-1:0] mem_rdata_q;
  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_addr;

  // register file
  logic [XLEN-1:0] rf_mem [8];
  logic [XLEN-1:0] rf_a_q;
  logic [XLEN-1:0] rf_b_q;
  logic [2:0]      rf_raddr_a;
  logic [2:0]      rf_raddr_b;
  logic            rf_we;
  logic [2:0]      rf_waddr;
  logic [XLEN-1:0] rf_wdata;

  // execute
  logic [4:0]      op;
  logic [4:0]      fetch_op;
  logic            exe_wr;
  logic [XLEN-1:0] exe_val;
  logic [XLEN-1:0] exe_pc;
  logic [XLEN-1:0] mul_full_lo;
  logic            div_go;

  div_req_t        div_req;
  div_rsp_t        div_rsp;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Word memory: load writes at accept, a step reads the word at the PC.
  // --------------------------------------------------------------------------
  assign mem_we   = in_acc && (kind_i == KIND_LOAD);
  assign mem_re   = in_acc && (kind_i == KIND_STEP) && (pc_q != HALT_PC);
  assign mem_addr = wrap_addr(mem_we ? address_i : pc_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= data_i;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Register-file read addresses come straight from the fetched word.
  // Port A: destination, or SET source (bits 2:0), or JMP target (bits 9:7).
  // --------------------------------------------------------------------------
  assign fetch_op = mem_rdata_q[15:11];

  always_comb begin
    rf_raddr_b = mem_rdata_q[7:5];
    if (fetch_op == OP_SET) begin
      rf_raddr_a = mem_rdata_q[2:0];
    end else if (fetch_op == OP_JMP) begin
      rf_raddr_a = mem_rdata_q[9:7];
    end else begin
      rf_raddr_a = mem_rdata_q[10:8];
    end
  end

  // Entries not written since reset read as zero through the valid bits.
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    if (state_q == S_FETCH) begin
      rf_a_q <= rf_vld_q[rf_raddr_a] ? rf_mem[rf_raddr_a] : '0;
      rf_b_q <= rf_vld_q[rf_raddr_b] ? rf_mem[rf_raddr_b] : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Execute: operands are the registered read data, pc_q is already bumped.
  // --------------------------------------------------------------------------
  assign op          = instr_q[15:11];
  assign mul_full_lo = XLEN'(rf_a_q * rf_b_q);

  always_comb begin
    exe_wr  = 1'b1;
    exe_val = '0;
    exe_pc  = pc_q;
    div_go  = 1'b0;
    unique case (op)
      OP_SET: exe_val = instr_q[7] ? rf_a_q : {9'd0, instr_q[6:0]};
      OP_ADD: exe_val = rf_a_q + rf_b_q;
      OP_ADI: exe_val = rf_a_q + {8'd0, instr_q[7:0]};
      OP_SUB: exe_val = rf_a_q - rf_b_q;
      OP_MUL: exe_val = mul_full_lo;
      OP_DIV: div_go  = (rf_b_q != '0);  // divide by zero yields 0
      OP_NOT: exe_val = ~rf_a_q;
      OP_JMP: begin
        exe_wr = 1'b0;
        if (instr_q[10]) begin
          exe_pc = pc_q + {{6{instr_q[9]}}, instr_q[9:0]};
        end else begin
          exe_pc = rf_a_q;
        end
      end
      default: exe_wr = 1'b0;
    endcase
  end

  assign div_req.start    = (state_q == S_EXEC) && div_go;
  assign div_req.dividend = rf_a_q;
  assign div_req.divisor  = rf_b_q;

  tcpu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign rf_we    = ((state_q == S_EXEC) && exe_wr && !div_go) ||
                    ((state_q == S_DIV) && div_rsp.done);
  assign rf_waddr = instr_q[10:8];
  assign rf_wdata = (state_q == S_DIV) ? div_rsp.quotient : exe_val;

  // --------------------------------------------------------------------------
  // Sequencer, architectural state and output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      instr_q     <= '0;
      rf_vld_q    <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // output register: refill from S_OUT, or drop once taken
      if ((state_q == S_OUT) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if ((kind_i == KIND_STEP) && (pc_q != HALT_PC)) begin
              state_q <= S_FETCH;
            end else begin
              state_q <= S_OUT;
            end
            if (kind_i == KIND_SRST) begin
              pc_q     <= '0;
              instr_q  <= '0;
              rf_vld_q <= '0;
              res_q    <= '0;
            end else begin
              res_q <= '{pc: pc_q, instr: '0,
                         halted: (kind_i == KIND_STEP) && (pc_q == HALT_PC),
                         wr: 1'b0, idx: '0, val: '0};
            end
          end
        end
        S_FETCH: begin
          instr_q <= mem_rdata_q;
          pc_q    <= pc_q + 1'b1;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          pc_q    <= exe_pc;
          res_q   <= '{pc: exe_pc, instr: instr_q, halted: 1'b0, wr: exe_wr,
                       idx: exe_wr ? instr_q[10:8] : 3'd0, val: exe_val};
          state_q <= div_go ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_q.val <= div_rsp.quotient;
            state_q   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign program_counter_o = out_q.pc;
  assign instruction_o     = out_q.instr;
  assign halted_o          = out_q.halted;
  assign reg_written_o     = out_q.wr;
  assign reg_index_o       = out_q.idx;
  assign reg_value_o       = out_q.val;

`ifndef SYNTH
  // register file is written only by an executing or dividing step
  a_rf_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> (state_q == S_EXEC || state_q == S_DIV))
    else $error("register write outside execute");

  // divider completes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider done while not waiting");

  // soft reset result carries PC zero and clears the PC
  a_srst_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == KIND_SRST) |=> (res_q.pc == '0 && pc_q == '0))
    else $error("soft reset did not clear PC");

  // a halted step never reports a register write
  a_halt_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(halted_o && reg_written_o))
    else $error("halted step reported a write");
`endif

endmodule

>>> sv/tcpu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpu_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcpu_div
  import tcpu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CntW = $clog2(XLEN);
  localparam logic [CntW-1:0] LastCnt = CntW'(XLEN - 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [XLEN-1:0] rem_q;
  logic [XLEN-1:0] quo_q;
  logic [XLEN-1:0] dvs_q;

  logic [XLEN:0]   trial;
  logic            ge;
  logic [XLEN:0]   diff;

  assign trial = {rem_q, quo_q[XLEN-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // one-cycle pulse after the last quotient bit
      done_q <= busy_q && !req_i.start && (cnt_q == LastCnt);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[XLEN-1:0] : trial[XLEN-1:0];
      quo_q <= {quo_q[XLEN-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> tb/sv/tiny_16bit_cpu_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_16bit_cpu_core_tb
// Self-checking bench for the tiny 16-bit processor core.
// A behavioral copy of the core (registers, PC, memory image) predicts the
// result of every accepted item. A checker compares each delivered result
// with the oldest prediction. Stimulus is a short directed program followed
// by random programs. Every fetched word is loaded before it is stepped.
// Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module tiny_16bit_cpu_core_tb;
  import tcpu_pkg::*;

  localparam int          MEM_WORDS    = 65536;
  localparam int          RANDOM_ITEMS = 1500;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          TAIL_CYCLES  = 40;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam logic [4:0]  OP_UNUSED    = 5'd31;

  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] instr;
    logic        halted;
    logic        wr;
    logic [2:0]  idx;
    logic [15:0] val;
  } cpu_result_t;

  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PERIODIC} ready_mode_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i      = KIND_LOAD;
  logic [15:0] address_i   = '0;
  logic [15:0] data_i      = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] program_counter_o;
  logic [15:0] instruction_o;
  logic        halted_o;
  logic        reg_written_o;
  logic [2:0]  reg_index_o;
  logic [15:0] reg_value_o;

  // Behavioral copy of the core state
  logic [15:0] model_regs [8] = '{default: 16'h0000};
  logic [15:0] model_pc       = '0;
  logic [15:0] mem_image [MEM_WORDS];
  bit          mem_loaded [MEM_WORDS];

  cpu_result_t pending_results [$];
  int          error_count    = 0;
  int          cycle_count    = 0;
  int          items_accepted = 0;
  int          burst_left     = 0;
  ready_mode_e ready_mode     = READY_ALWAYS;
  int          ready_phase    = 0;

  tiny_16bit_cpu_core #(
    .MEM_WORDS(MEM_WORDS)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .address_i         (address_i),
    .data_i            (data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .program_counter_o (program_counter_o),
    .instruction_o     (instruction_o),
    .halted_o          (halted_o),
    .reg_written_o     (reg_written_o),
    .reg_index_o       (reg_index_o),
    .reg_value_o       (reg_value_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver back-pressure: phases of always-ready, light, heavy and periodic stalls
  always @(posedge clk_i) begin
    if (ready_phase == 0) begin
      ready_mode  = ready_mode_e'($urandom_range(0, 3));
      ready_phase = $urandom_range(20, 300);
    end
    ready_phase--;
    case (ready_mode)
      READY_ALWAYS:  out_ready_i <= 1'b1;
      READY_MOSTLY:  out_ready_i <= ($urandom_range(0, 3) != 0);
      READY_RARELY:  out_ready_i <= ($urandom_range(0, 3) == 0);
      default:       out_ready_i <= (cycle_count % 5 == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Prediction: apply one accepted item to the behavioral state and queue
  // the result it must produce.
  // --------------------------------------------------------------------------
  task automatic predict_cpu_result(input logic [1:0] kind, input logic [15:0] addr,
                                    input logic [15:0] data);
    cpu_result_t r;
    logic [15:0] word;
    logic [4:0]  op;
    logic [2:0]  rd;
    logic [2:0]  rs;
    r = '0;
    case (kind)
      KIND_LOAD: begin
        mem_image[addr % MEM_WORDS]  = data;
        mem_loaded[addr % MEM_WORDS] = 1'b1;
      end
      KIND_SRST: begin
        model_regs = '{default: 16'h0000};
        model_pc   = '0;
      end
      KIND_STEP: begin
        if (model_pc == HALT_PC) begin
          r.halted = 1'b1;
        end else begin
          word     = mem_image[model_pc % MEM_WORDS];
          model_pc = model_pc + 16'd1;
          op       = word[15:11];
          rd       = word[10:8];
          rs       = word[7:5];
          r.instr  = word;
          r.wr     = 1'b1;
          r.idx    = rd;
          case (op)
            OP_SET: r.val = word[7] ? model_regs[word[2:0]] : {9'd0, word[6:0]};
            OP_ADD: r.val = model_regs[rd] + model_regs[rs];
            OP_ADI: r.val = model_regs[rd] + {8'd0, word[7:0]};
            OP_SUB: r.val = model_regs[rd] - model_regs[rs];
            OP_MUL: r.val = model_regs[rd] * model_regs[rs];
            OP_DIV: r.val = (model_regs[rs] != 16'd0) ? model_regs[rd] / model_regs[rs] : '0;
            OP_NOT: r.val = ~model_regs[rd];
            OP_JMP: begin
              r.wr = 1'b0;
              // relative target is taken from the already incremented PC
              if (word[10]) model_pc = model_pc + {{6{word[9]}}, word[9:0]};
              else          model_pc = model_regs[word[9:7]];
            end
            default: r.wr = 1'b0;
          endcase
          if (r.wr) begin
            model_regs[rd] = r.val;
          end else begin
            r.idx = '0;
            r.val = '0;
          end
        end
      end
      default: ;
    endcase
    r.pc = model_pc;
    pending_results.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%04h, got 0x%04h", field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    cpu_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result item with no prediction waiting");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("program_counter", want.pc, program_counter_o);
        check_field("instruction", want.instr, instruction_o);
        check_field("halted", {15'd0, want.halted}, {15'd0, halted_o});
        check_field("reg_written", {15'd0, want.wr}, {15'd0, reg_written_o});
        check_field("reg_index", {13'd0, want.idx}, {13'd0, reg_index_o});
        check_field("reg_value", want.val, reg_value_o);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: items go out in bursts of random length with random gaps
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] kind, input logic [15:0] addr,
                           input logic [15:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    address_i  <= addr;
    data_i     <= data;
    do @(posedge clk_i); while (!in_ready_o);
    predict_cpu_result(kind, addr, data);
    if (kind != KIND_UNUSED) items_accepted++;
  endtask

  // Drop valid and hold off until every predicted result has been delivered
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_instr();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(0, 19))
      0, 1, 2: w[15:11] = OP_SET;
      3, 4:    w[15:11] = OP_ADD;
      5, 6:    w[15:11] = OP_ADI;
      7, 8:    w[15:11] = OP_SUB;
      9, 10:   w[15:11] = OP_MUL;
      11, 12:  w[15:11] = OP_DIV;
      13:      w[15:11] = OP_NOT;
      14, 15:  w[15:11] = OP_JMP;
      default: ;  // any opcode, unused ones included
    endcase
    return w;
  endfunction

  // Step once; a word never loaded is filled first so no fetch reads junk
  task automatic step_cpu(input logic [15:0] word, input bit use_word);
    if (model_pc != HALT_PC && (use_word || !mem_loaded[model_pc % MEM_WORDS]))
      send_item(KIND_LOAD, model_pc, use_word ? word : random_instr());
    send_item(KIND_STEP, 16'($urandom), 16'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_arithmetic();
    step_cpu({OP_SET, 3'd1, 1'b0, 7'h7F}, 1);          // immediate form, largest value
    step_cpu({OP_NOT, 3'd3, 8'h00}, 1);                // r3 = 0xFFFF
    step_cpu({OP_ADI, 3'd2, 8'hFF}, 1);                // largest immediate
    step_cpu({OP_ADD, 3'd2, 3'd3, 5'd0}, 1);           // add wraps
    step_cpu({OP_SUB, 3'd4, 3'd1, 5'd0}, 1);           // subtract wraps below zero
    step_cpu({OP_MUL, 3'd4, 3'd3, 5'd0}, 1);           // product keeps low 16 bits
    step_cpu({OP_SET, 3'd7, 1'b1, 4'hF, 3'd3}, 1);     // register form, r7 = 0xFFFF
    step_cpu({OP_DIV, 3'd3, 3'd2, 5'd0}, 1);
    step_cpu({OP_DIV, 3'd1, 3'd0, 5'd0}, 1);           // divide by zero gives 0
    step_cpu({OP_UNUSED, 11'h7FF}, 1);                 // unused opcode: fetch only
  endtask

  task automatic test_jumps_and_halt();
    step_cpu({OP_JMP, 1'b1, 10'h3FF}, 1);              // relative -1: lands on itself
    step_cpu('0, 0);                                   // executes the same word again
    step_cpu({OP_JMP, 1'b0, 3'd7, 7'h7F}, 1);          // absolute through r7 to 0xFFFF
    step_cpu('0, 0);                                   // halted step
  endtask

  task automatic test_loads_and_kinds();
    send_item(KIND_LOAD, 16'hFFFF, 16'hFFFF);
    send_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF);
    send_item(KIND_SRST, 16'h0000, 16'h0000);
  endtask

  task automatic test_random_programs();
    int start_count;
    int pick;
    bit drained;
    start_count = items_accepted;
    drained     = 0;
    while (items_accepted - start_count < RANDOM_ITEMS) begin
      if ((!drained && items_accepted - start_count >= RANDOM_ITEMS / 2) ||
          $urandom_range(0, 199) == 0) begin
        wait_drained();
        drained = 1;
      end
      pick = $urandom_range(0, 99);
      if (model_pc == HALT_PC && pick < 60)
        send_item(KIND_SRST, 16'($urandom), 16'($urandom));
      else if (pick < 72)
        step_cpu('0, 0);
      else if (pick < 86)   // rewrite code just ahead of the PC
        send_item(KIND_LOAD, model_pc + 16'($urandom_range(0, 8)), random_instr());
      else if (pick < 94)   // noise: any address, any word
        send_item(KIND_LOAD, 16'($urandom), 16'($urandom));
      else if (pick < 97)
        send_item(KIND_SRST, 16'($urandom), 16'($urandom));
      else
        send_item(KIND_UNUSED, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_arithmetic();
    test_jumps_and_halt();
    test_loads_and_kinds();
    test_random_programs();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
sv/tcpu_pkg.sv
sv/tcpu_div.sv
sv/tiny_16bit_cpu_core.sv
tb/sv/tiny_16bit_cpu_core_tb.sv
